/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by bma_ctrl to check its own logic.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bma_pkg.sv */
// ---------------------------------------------------------------------------
// bma_pkg
// Types and fixed constants of the binned mean accumulator.
// ---------------------------------------------------------------------------
package bma_pkg;

    localparam int CFG_W       = 31;
    localparam int POS_W       = 32;
    localparam int MEAN_W      = 32;
    localparam int EDGE_OUT_W  = 44;
    localparam int INDEX_OUT_W = 12;
    localparam int STEPS_W     = 6;

    localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 31'd65536;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_EMIT   = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RNG,
        S_SDIV,
        S_SRD,
        S_SWR,
        S_ERD,
        S_ECHK,
        S_EDIV,
        S_EOUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic rng;
        logic rd_s;
        logic wr_s;
        logic rd_e;
        logic chk;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic rng_ok;
        logic div_done;
        logic rem_zero;
        logic cnt_zero;
        logic out_free;
    } t_sts;

endpackage

/* hdl/bma_if.sv */
// ---------------------------------------------------------------------------
// bma_in_if / bma_out_if
// Valid/ready channels carrying sample/emit items and bin results.
// ---------------------------------------------------------------------------
interface bma_in_if;
    import bma_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  momentum;

    modport source (output valid, kind, position, momentum, input ready);
    modport sink (input valid, kind, position, momentum, output ready);
endinterface

interface bma_out_if;
    import bma_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [INDEX_OUT_W-1:0]        bin_index;
    logic signed [EDGE_OUT_W-1:0]  left_edge;
    logic signed [MEAN_W-1:0]      mean_value;
    logic                          held;
    logic                          is_last;
    logic [MEAN_W-1:0]             max_abs;

    modport source (output valid, bin_index, left_edge, mean_value, held, is_last, max_abs,
                    input ready);
    modport sink (input valid, bin_index, left_edge, mean_value, held, is_last, max_abs,
                  output ready);
endinterface

/* hdl/bma_div.sv */
// ---------------------------------------------------------------------------
// bma_div
// Restoring divider, one quotient bit per cycle, pre-shifted divisor.
// ---------------------------------------------------------------------------
module bma_div #(
    parameter int R_W = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bma_pkg::STEPS_W-1:0] i_steps,
    input  logic [R_W-1:0]             i_dividend,
    input  logic [R_W-1:0]             i_divisor,
    output logic                       o_done,
    output logic                       o_rem_zero,
    output logic [bma_pkg::MEAN_W-1:0] o_quot
);
    import bma_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [STEPS_W-1:0] r_cnt, n_cnt;
    logic [R_W-1:0]     r_rem, n_rem;
    logic [R_W-1:0]     r_dsh, n_dsh;
    logic [MEAN_W-1:0]  r_q, n_q;
    logic               ge;

    assign ge = (r_rem >= r_dsh);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
            n_rem  = i_dividend;
            n_dsh  = i_divisor;
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = ge ? (r_rem - r_dsh) : r_rem;
            n_q   = {r_q[MEAN_W-2:0], ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - STEPS_W'(1);
            if (r_cnt == STEPS_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);
    assign o_quot     = r_q;

endmodule

/* hdl/bma_ctrl.sv */
// ---------------------------------------------------------------------------
// bma_ctrl
// Sequencer for clear pass, sample update and bin readout.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bma_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    input  bma_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output bma_pkg::t_cmd o_cmd
);
    import bma_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) n_state = (i_in_kind == KIND_EMIT) ? S_ERD : S_RNG;
            end
            S_RNG:   n_state = i_sts.rng_ok ? S_SDIV : S_IDLE;
            S_SDIV: begin
                if (i_sts.div_done) n_state = i_sts.rem_zero ? S_IDLE : S_SRD;
            end
            S_SRD:   n_state = S_SWR;
            S_SWR:   n_state = S_IDLE;
            S_ERD:   n_state = S_ECHK;
            S_ECHK:  n_state = i_sts.cnt_zero ? S_EOUT : S_EDIV;
            S_EDIV:  if (i_sts.div_done) n_state = S_EOUT;
            S_EOUT:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_RNG:   o_cmd.rng = 1'b1;
            S_SRD:   o_cmd.rd_s = 1'b1;
            S_SWR:   o_cmd.wr_s = 1'b1;
            S_ERD:   o_cmd.rd_e = 1'b1;
            S_ECHK:  o_cmd.chk = 1'b1;
            S_EOUT:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_emit_starts_read, r_state == S_IDLE && i_in_valid && i_in_kind == KIND_EMIT, r_state == S_ERD, "emit transaction did not start a bin read")
    `ASSERT_IMPLIES(a_load_when_free, o_cmd.out_load, r_state == S_EOUT && i_sts.out_free, "result loaded outside readout or into a full register")
    `ASSERT_NEXT(a_hold_mean_div, r_state == S_EDIV && !i_sts.div_done, r_state == S_EDIV, "left mean division before it finished")

endmodule

/* hdl/bma_dp.sv */
// ---------------------------------------------------------------------------
// bma_dp
// Bin store, range check, shared divider and result register.
// ---------------------------------------------------------------------------
module bma_dp #(
    parameter int BINS       = 4096,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bma_pkg::t_cmd                     i_cmd,
    output bma_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_in_kind,
    input  logic signed [bma_pkg::POS_W-1:0]  i_in_position,
    input  logic signed [bma_pkg::POS_W-1:0]  i_in_momentum,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [bma_pkg::INDEX_OUT_W-1:0]   o_bin_index,
    output logic signed [bma_pkg::EDGE_OUT_W-1:0] o_left_edge,
    output logic signed [bma_pkg::MEAN_W-1:0] o_mean_value,
    output logic                              o_held,
    output logic                              o_is_last,
    output logic [bma_pkg::MEAN_W-1:0]        o_max_abs
);
    import bma_pkg::*;

    localparam int IDX_W    = $clog2(BINS);
    localparam int BIN_BITS = $clog2(BINS + 1);
    localparam int TOT_W    = CFG_W + BIN_BITS;
    localparam int OFF_W    = TOT_W + 2;
    localparam int SUM_W    = MEAN_W + COUNT_BITS;
    localparam int R_W      = (OFF_W > SUM_W) ? OFF_W : SUM_W;
    localparam int ENT_W    = SUM_W + COUNT_BITS;
    localparam int PROD_W   = IDX_W + CFG_W;
    localparam int EDGE_W   = TOT_W + 2;
    localparam int MEAN_SH  = MEAN_W - 1;
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(BINS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_TOP  = '1;

    // configuration and derived range
    logic [CFG_W-1:0] r_bin_width;
    logic [TOT_W-1:0] r_total;

    // item registers
    logic signed [POS_W-1:0] r_pos, r_mom;
    logic [MEAN_W-1:0]       r_max;
    logic [MEAN_W-1:0]       mag;

    // readout state
    logic [IDX_W-1:0]         r_rptr;
    logic signed [MEAN_W-1:0] r_prev;
    logic                     r_neg, r_held;
    logic [PROD_W-1:0]        r_prod;

    // clearing sweep
    logic [IDX_W-1:0] r_clr_addr;

    // bin store
    logic [ENT_W-1:0] mem [BINS];
    logic [ENT_W-1:0] r_rd;
    logic             we, re;
    logic [IDX_W-1:0] waddr, raddr;
    logic [ENT_W-1:0] wdata;
    logic signed [SUM_W-1:0] rd_sum;
    logic [COUNT_BITS-1:0]   rd_cnt;
    logic [SUM_W-1:0]        sum_abs;

    // range and divider
    logic signed [OFF_W-1:0] off2, lim;
    logic                    rng_ok;
    logic                    div_start, div_done, rem_zero;
    logic [STEPS_W-1:0]      div_steps;
    logic [R_W-1:0]          div_dividend, div_divisor;
    logic [MEAN_W-1:0]       quot;
    logic [IDX_W-1:0]        s_idx;

    // result
    logic signed [MEAN_W-1:0] mean_v;
    logic signed [EDGE_W-1:0] lft_dbl, lft_v;
    logic signed [63:0]       lft_x;
    logic [15:0]              idx16;
    logic                     is_last;
    logic                     r_out_valid;
    logic                     out_free;

    assign mag    = i_in_momentum[POS_W-1] ? MEAN_W'(-i_in_momentum) : MEAN_W'(i_in_momentum);
    assign rd_cnt = r_rd[COUNT_BITS-1:0];
    assign rd_sum = $signed(r_rd[ENT_W-1:COUNT_BITS]);
    assign sum_abs = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);

    assign off2   = (OFF_W'(r_pos) <<< 1) + $signed(OFF_W'(r_total));
    assign lim    = $signed({1'b0, r_total, 1'b0});
    assign rng_ok = (off2 > 0) && (off2 < lim);
    assign s_idx  = quot[IDX_W-1:0];

    assign div_start    = (i_cmd.rng && rng_ok) || (i_cmd.chk && rd_cnt != '0);
    assign div_steps    = i_cmd.chk ? STEPS_W'(MEAN_W) : STEPS_W'(IDX_W);
    assign div_dividend = i_cmd.chk ? R_W'(sum_abs) : R_W'($unsigned(off2));
    assign div_divisor  = i_cmd.chk ? (R_W'(rd_cnt) << MEAN_SH)
                                    : (R_W'(r_bin_width) << IDX_W);

    bma_div #(.R_W(R_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem_zero (rem_zero),
        .o_quot     (quot)
    );

    // store ports: clear sweep, emit clear or sample update share the write port
    always_comb begin
        we    = 1'b0;
        waddr = r_rptr;
        wdata = '0;
        if (i_cmd.clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (i_cmd.chk) begin
            we    = 1'b1;
            waddr = r_rptr;
        end else if (i_cmd.wr_s && rd_cnt != CNT_TOP) begin
            we    = 1'b1;
            waddr = s_idx;
            wdata = {SUM_W'(rd_sum + SUM_W'(r_mom)), rd_cnt + COUNT_BITS'(1)};
        end
    end

    assign re    = i_cmd.rd_s || i_cmd.rd_e;
    assign raddr = i_cmd.rd_s ? s_idx : r_rptr;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rd <= mem[raddr];
    end

    assign mean_v  = r_held ? ((r_rptr == '0) ? '0 : r_prev)
                            : (r_neg ? -$signed(quot) : $signed(quot));
    assign lft_dbl = $signed(EDGE_W'({r_prod, 1'b0})) - $signed(EDGE_W'(r_total));
    assign lft_v   = lft_dbl >>> 1;
    assign lft_x   = 64'(lft_v);
    assign idx16   = 16'(r_rptr);
    assign is_last = (r_rptr == LAST_IDX);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= BIN_WIDTH_RST;
            r_total     <= '0;
            r_max       <= '0;
            r_rptr      <= '0;
            r_prev      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_bin_width <= i_cfg_wdata;
            r_total <= TOT_W'(r_bin_width) * TOT_W'(BINS);
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (i_cmd.load && i_in_kind == KIND_SAMPLE && mag > r_max) r_max <= mag;
            if (i_cmd.out_load) begin
                r_prev <= mean_v;
                r_rptr <= is_last ? '0 : r_rptr + IDX_W'(1);
                if (is_last) r_max <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= i_in_position;
            r_mom <= i_in_momentum;
        end
        if (i_cmd.chk) begin
            r_neg  <= rd_sum[SUM_W-1];
            r_held <= (rd_cnt == '0);
            r_prod <= PROD_W'(r_rptr) * PROD_W'(r_bin_width);
        end
        if (i_cmd.out_load) begin
            o_bin_index  <= idx16[INDEX_OUT_W-1:0];
            o_left_edge  <= lft_x[EDGE_OUT_W-1:0];
            o_mean_value <= mean_v;
            o_held       <= r_held;
            o_is_last    <= is_last;
            o_max_abs    <= r_max;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.clr_last  = (r_clr_addr == LAST_IDX);
    assign o_sts.rng_ok    = rng_ok;
    assign o_sts.div_done  = div_done;
    assign o_sts.rem_zero  = rem_zero;
    assign o_sts.cnt_zero  = (rd_cnt == '0);
    assign o_sts.out_free  = out_free;

endmodule

/* hdl/binned_mean_accumulator.sv */
// ---------------------------------------------------------------------------
// binned_mean_accumulator
// Histogram of mean momentum over equal position bins, Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per item: kind 0 adds a (position, momentum)
//   sample to its bin, kind 1 reads out and clears the next bin in order.
//   o_out carries one result transaction per emit item: bin index, left
//   edge, mean (truncated toward zero, held from the prior bin if empty),
//   held and last flags, and the largest |momentum| since the last pass.
//   i_cfg_we/i_cfg_wdata write bin_width; write it only while idle.
// Sequence:
//   A kept sample passes from its accept through the range check, a
//   division in the shared restoring divider with one step per index
//   bit and its registered done flag, then a read and a write of the bin
//   store. An out of range sample returns to idle after the range check,
//   one on a bin edge after the division.
//   An emit of a filled bin reads and checks the bin, then waits for the
//   32 quotient bits of the mean division; an empty bin skips the division.
// Reset:
//   After i_rst_n a clearing sweep zeroes the store, one bin per cycle,
//   through every bin; i_in.ready stays low meanwhile.
// Stall:
//   The result register holds a result while o_out.ready is low; the block
//   keeps taking items, and a later emit waits only at its final load.
// ---------------------------------------------------------------------------
module binned_mean_accumulator #(
    parameter int BINS       = 4096,
    parameter int COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0] i_cfg_wdata,
    bma_in_if.sink                    i_in,
    bma_out_if.source                 o_out
);
    import bma_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // sequencer: owns the handshake toward the input side
    bma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // datapath: store, divider and the result register
    bma_dp #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_kind     (i_in.kind),
        .i_in_position (i_in.position),
        .i_in_momentum (i_in.momentum),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_bin_index   (o_out.bin_index),
        .o_left_edge   (o_out.left_edge),
        .o_mean_value  (o_out.mean_value),
        .o_held        (o_out.held),
        .o_is_last     (o_out.is_last),
        .o_max_abs     (o_out.max_abs)
    );

endmodule

/* sim/bma_checker.sv */
// ---------------------------------------------------------------------------
// bma_checker
// Watches the item, result and bin width ports of the binned mean
// accumulator. Predicts each result from its own copy of the bin store and
// compares the result with the oldest prediction across all fields.
// ---------------------------------------------------------------------------
module bma_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0] i_cfg_wdata,
    bma_in_if                         i_in,
    bma_out_if                        i_out,
    output int                        o_errors,
    output int                        o_pending
);
    import bma_pkg::*;

    localparam int NBINS     = 4096;
    localparam int COUNT_TOP = 65535;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0]       bin_index;
        logic signed [EDGE_OUT_W-1:0] left_edge;
        logic signed [MEAN_W-1:0]     mean_value;
        logic                         held;
        logic                         is_last;
        logic [MEAN_W-1:0]            max_abs;
    } t_bin_report;

    longint      sum_store [NBINS];
    int          count_store [NBINS];
    int          next_bin;
    logic signed [31:0] last_mean;
    logic [31:0] peak_mag;
    longint      width;
    t_bin_report report_q [$];

    // file one sample into its bin, or drop it
    task automatic add_sample(input logic signed [31:0] pos, input logic signed [31:0] mom);
        longint mag, total, off2, w2, b;
        mag = (mom < 0) ? -longint'(mom) : longint'(mom);
        if (mag > longint'(peak_mag)) peak_mag = mag[31:0];
        if (width == 0) return;
        total = width * NBINS;
        off2  = 2 * longint'(pos) + total;
        if (off2 <= 0 || off2 >= 2 * total) return;
        w2 = 2 * width;
        if (off2 % w2 == 0) return;
        b = off2 / w2;
        if (b < 0 || b >= NBINS) return;
        if (count_store[b] >= COUNT_TOP) return;
        count_store[b]++;
        sum_store[b] += longint'(mom);
    endtask

    // read out and clear the next bin
    task automatic read_bin();
        t_bin_report r;
        longint e;
        r.bin_index = next_bin[INDEX_OUT_W-1:0];
        if (count_store[next_bin] != 0) begin
            r.mean_value = MEAN_W'(sum_store[next_bin] / longint'(count_store[next_bin]));
            r.held       = 1'b0;
        end else begin
            r.mean_value = (next_bin == 0) ? '0 : last_mean;
            r.held       = 1'b1;
        end
        last_mean   = r.mean_value;
        e           = longint'(next_bin) * width - width * (NBINS / 2);
        r.left_edge = e[EDGE_OUT_W-1:0];
        r.is_last   = (next_bin == NBINS - 1);
        r.max_abs   = peak_mag;
        report_q.push_back(r);
        sum_store[next_bin]   = 0;
        count_store[next_bin] = 0;
        if (r.is_last) begin
            next_bin = 0;
            peak_mag = '0;
        end else begin
            next_bin++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_report want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < NBINS; i++) begin
                sum_store[i]   = 0;
                count_store[i] = 0;
            end
            next_bin  = 0;
            last_mean = '0;
            peak_mag  = '0;
            width     = longint'(BIN_WIDTH_RST);
            report_q.delete();
            o_errors  <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.bin_index, i_out.left_edge, i_out.mean_value,
                        i_out.held, i_out.is_last, i_out.max_abs};
                if (report_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result: %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = report_q.pop_front();
                    if (want !== got) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == KIND_EMIT) read_bin();
                else add_sample(i_in.position, i_in.momentum);
            end
            if (i_cfg_we) width = longint'(i_cfg_wdata);
        end
        o_pending <= report_q.size();
    end
endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Drives the binned mean accumulator with directed and random samples and
// emits over several bin widths and idling patterns; the checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
    import bma_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               errors, pending;

    int     send_idle_pct;
    int     stall_pct;
    int     hold_asks;
    int     hold_done = 0;
    int     hold_left = 0;
    int     emit_ptr;   // next bin to be read, tracked on the stimulus side
    longint cur_width;

    bma_in_if  in_ch ();
    bma_out_if out_ch ();

    binned_mean_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    bma_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a long stretch when asked so
    // that the result register fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_asks != hold_done) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 400;
            hold_done    <= hold_asks;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one transaction, idling first at random; hold it until accepted.
    task automatic send_item(input logic k, input logic [31:0] pos, input logic [31:0] mom);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= k;
        in_ch.position <= pos;
        in_ch.momentum <= mom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (k == KIND_EMIT) emit_ptr = (emit_ptr + 1) % 4096;
    endtask

    // Momentum mix: full random, small values and the extremes.
    function automatic logic [31:0] pick_momentum();
        case ($urandom_range(3))
            0, 1: return $urandom;
            2:    return 32'($signed($urandom_range(2000)) - 1000);
            default: begin
                case ($urandom_range(2))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    // Mostly samples aimed at the bins about to be read, some noise, some emits.
    task automatic send_random();
        int     r, b;
        longint off, pos;
        r = $urandom_range(99);
        if (r < 25) begin
            send_item(KIND_EMIT, $urandom, $urandom);
        end else if (r < 35) begin
            send_item(KIND_SAMPLE, $urandom, pick_momentum());
        end else begin
            b   = (emit_ptr + $urandom_range(3)) % 4096;
            off = (cur_width > 1) ? longint'($urandom_range(32'(cur_width - 1))) : 0;
            if ($urandom_range(7) == 0) off = 0;   // land on the bin edge
            pos = longint'(b - 2048) * cur_width + off;
            send_item(KIND_SAMPLE, pos[31:0], pick_momentum());
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_width(input longint w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_width = w;
    endtask

    initial begin
        longint widths [7] = '{65536, 1, 3, 2147483647, 0, 1000, 65536};
        longint h;
        int     n;

        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= KIND_SAMPLE;
        in_ch.position <= '0;
        in_ch.momentum <= '0;
        hold_asks      = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        emit_ptr       = 0;
        cur_width      = 65536;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset width: range is +/- 2^27.
        h = 64'd134217728;
        send_item(KIND_EMIT, 0, 0);                                  // empty first bin
        send_item(KIND_SAMPLE, 32'(-h), 32'd5);                      // on the low limit
        send_item(KIND_SAMPLE, 32'(-h + 1), 32'h7FFF_FFFF);
        send_item(KIND_SAMPLE, 32'h8000_0000, 32'h8000_0000);        // out of range
        send_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0);
        send_item(KIND_SAMPLE, 32'(h), 32'd9);                       // on the high limit
        send_item(KIND_SAMPLE, 32'h0, 32'd3);                        // on a bin edge
        send_item(KIND_SAMPLE, 32'(-h + 65536), 32'd4);              // edge of bin 1
        send_item(KIND_SAMPLE, 32'(-h + 65537), 32'hFFFF_FFFB);
        send_item(KIND_SAMPLE, 32'(-h + 65537), 32'd2);
        send_item(KIND_SAMPLE, 32'(-h + 140000), 32'h8000_0000);
        send_item(KIND_SAMPLE, 32'(h - 1), 32'd7);                   // last bin
        send_item(KIND_EMIT, 0, 0);
        send_item(KIND_EMIT, 0, 0);                                  // one sample of the most negative momentum
        send_item(KIND_EMIT, 0, 0);
        send_item(KIND_EMIT, 0, 0);                                  // empty later bin
        send_item(KIND_SAMPLE, 32'(-h + 65537), 32'd11);             // bin already read

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_width(widths[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            if (ph == 2) hold_asks++;   // long receiver hold-off with the sender busy
            n = (ph == 4) ? 30 : 80;
            repeat (n) send_random();
        end

        // Close with a short random stretch at full rate.
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (20) send_random();

        drain();
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule

/* binned_mean_accumulator.f */
+incdir+hdl
hdl/bma_pkg.sv
hdl/bma_if.sv
hdl/bma_div.sv
hdl/bma_ctrl.sv
hdl/bma_dp.sv
hdl/binned_mean_accumulator.sv
sim/bma_checker.sv
sim/tb_top.sv
